// File: sv/random_source_address_picker_core_defines.svh
// Assertion macros for the random source address picker.
`ifndef RANDOM_SOURCE_ADDRESS_PICKER_CORE_DEFINES_SVH
`define RANDOM_SOURCE_ADDRESS_PICKER_CORE_DEFINES_SVH

// Assert that an implication holds at every clock edge outside reset.
`define RSAP_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Assert that an implication holds in the cycle after the antecedent.
`define RSAP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/rsap_pkg.sv
// Types and constants shared by the address picker files.
`default_nettype none
package rsap_pkg;
    // entry_index is 4 bits and the counts are 5 bits, so the table size is fixed
    localparam int TABLE_ENTRIES = 16;

    localparam logic [2:0] OP_LOAD_V4 = 3'd0;
    localparam logic [2:0] OP_LOAD_V6 = 3'd1;
    localparam logic [2:0] OP_DEST_V4 = 3'd2;
    localparam logic [2:0] OP_DEST_V6 = 3'd3;
    localparam logic [2:0] OP_BIND_V4 = 3'd4;
    localparam logic [2:0] OP_BIND_V6 = 3'd5;

    localparam logic [2:0] ST_PASS     = 3'd0;
    localparam logic [2:0] ST_PICKED   = 3'd1;
    localparam logic [2:0] ST_FALLBACK = 3'd2;
    localparam logic [2:0] ST_DENIED   = 3'd3;
    localparam logic [2:0] ST_LOADED   = 3'd4;

    localparam logic [1:0] REG_V4_COUNT = 2'd0;
    localparam logic [1:0] REG_V6_COUNT = 2'd1;
    localparam logic [1:0] REG_FALLBACK = 2'd2;
    localparam logic [1:0] REG_SEED     = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [3:0]  entry_index;
        logic [7:0]  prefix_length;
        logic [63:0] address_high;
        logic [63:0] address_low;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        source_is_v6;
        logic [63:0] source_high;
        logic [63:0] source_low;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DRAW_IDX,
        S_MOD,
        S_READ,
        S_V4_TRY,
        S_V6_WORD,
        S_DONE
    } state_t;

    // one xorshift32 step
    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        begin
            a = x ^ (x << 13);
            b = a ^ (a >> 17);
            return b ^ (b << 5);
        end
    endfunction

    function automatic logic v4_special(input logic [31:0] a);
        return (a[31:24] == 8'h7f) || (a[31:28] == 4'he) || (a == 32'hffffffff);
    endfunction
endpackage
`default_nettype wire

// File: sv/rsap_if.sv
// Valid/ready channel carrying one item.
`default_nettype none
interface rsap_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/rsap_rng.sv
// xorshift32 generator with seed load.
`default_nettype none
module rsap_rng (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed,
    input  wire logic        step,
    output logic [31:0]      value
);
    import rsap_pkg::*;
    logic [31:0] state_reg;
    logic [31:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        if (seed_we)
            state_next = (seed == 32'd0) ? 32'd1 : seed;
        else if (step)
            state_next = xorshift(state_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= 32'd1;
        else
            state_reg <= state_next;
    end

    // new state is the drawn word
    assign value = xorshift(state_reg);
endmodule
`default_nettype wire

// File: sv/random_source_address_picker_core.sv
// Top level: random source address picker with APB register port.
// Steps: accept, S_DRAW_IDX, S_DONE for loads, passes and empty-table fails; a pick
// adds S_MOD (entry modulo) and S_READ, then v4 host tries (1..HOST_TRIES, none for a
// prefix of 32 or more) or the v6 word steps before S_DONE. One item at a time:
// in.ready is low from acceptance until the result is taken.
// Reset (rst_n, async) clears tables (via valid bits), counts and fallback; seed 1.
`default_nettype none
`include "random_source_address_picker_core_defines.svh"
module random_source_address_picker_core #(
    parameter int HOST_TRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    rsap_if.sink             in_ch,
    rsap_if.source           out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import rsap_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int TW = $clog2(HOST_TRIES + 1);

    // ---------------- registers ----------------
    logic [4:0]  v4_count_reg;
    logic [4:0]  v6_count_reg;
    logic        fallback_reg;
    logic [31:0] seed_reg;
    logic        cfg_we;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_count_reg <= 5'd0;
            v6_count_reg <= 5'd0;
            fallback_reg <= 1'b0;
            seed_reg     <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_V4_COUNT: v4_count_reg <= pwdata[4:0];
                REG_V6_COUNT: v6_count_reg <= pwdata[4:0];
                REG_FALLBACK: fallback_reg <= pwdata[0];
                REG_SEED:     seed_reg     <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_V4_COUNT: prdata = {27'd0, v4_count_reg};
            REG_V6_COUNT: prdata = {27'd0, v6_count_reg};
            REG_FALLBACK: prdata = {31'd0, fallback_reg};
            REG_SEED:     prdata = seed_reg;
            default:      prdata = 32'd0;
        endcase
    end

    // ---------------- tables, valid bits model the cleared reset ----------------
    logic [31:0] v4_addr_mem [TABLE_ENTRIES];
    logic [7:0]  v4_bits_mem [TABLE_ENTRIES];
    logic [63:0] v6_hi_mem   [TABLE_ENTRIES];
    logic [63:0] v6_lo_mem   [TABLE_ENTRIES];
    logic [7:0]  v6_bits_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] v4_vld_reg;
    logic [TABLE_ENTRIES-1:0] v6_vld_reg;

    // ---------------- sequencer ----------------
    state_t      state_reg, state_next;
    req_t        req_reg;
    rsp_t        rsp_reg, rsp_next;
    logic        rsp_valid_reg;
    logic [31:0] rem_reg, rem_next;      // drawn word, shifted out a nibble per cycle
    logic [4:0]  part_reg, part_next;    // running remainder, always below lim_reg
    logic [2:0]  mod_cnt_reg, mod_cnt_next;
    logic [5:0]  part_step;
    logic [IW-1:0] pick_idx;
    logic [4:0]  lim_reg, lim_next;
    logic        use_v4_reg, use_v4_next;
    logic        mapped_reg, mapped_next;
    logic [TW-1:0] try_reg, try_next;
    logic [1:0]  word_reg, word_next;
    logic [31:0] net_reg;
    logic [7:0]  bits_reg;
    logic [127:0] v6_net_reg;
    logic [127:0] acc_reg, acc_next;
    logic        rng_step;
    logic [31:0] rnd;
    logic        accept_in;

    rsap_rng u_rng (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (cfg_we && cfg_idx == REG_SEED),
        .seed    (pwdata),
        .step    (rng_step),
        .value   (rnd)
    );

    assign in_ch.ready  = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign accept_in    = in_ch.valid && in_ch.ready;
    assign out_ch.valid = rsp_valid_reg;
    assign out_ch.data  = rsp_reg;

    // decode of the accepted request
    logic        is_mapped;
    logic        pass;
    logic [4:0]  cnt_sat;
    assign is_mapped = (req_reg.address_high == 64'd0) &&
                       (req_reg.address_low[63:32] == 32'h0000ffff);

    always_comb
    begin
        case (req_reg.opcode)
            OP_DEST_V4: pass = v4_special(req_reg.address_low[31:0]);
            OP_DEST_V6: pass = (req_reg.address_high == 64'd0 && req_reg.address_low == 64'd1)
                            || (req_reg.address_high[63:56] == 8'hff)
                            || (req_reg.address_high[63:54] == 10'b1111111010)
                            || (is_mapped && v4_special(req_reg.address_low[31:0]));
            OP_BIND_V4: pass = req_reg.address_low[31:0] != 32'd0;
            OP_BIND_V6: pass = (req_reg.address_high | req_reg.address_low) != 64'd0;
            default:    pass = 1'b1;
        endcase
    end

    logic v4_path;
    assign v4_path = (req_reg.opcode == OP_DEST_V4) || (req_reg.opcode == OP_BIND_V4)
                     || (req_reg.opcode == OP_DEST_V6 && is_mapped);
    assign cnt_sat = v4_path
        ? ((v4_count_reg > 5'(TABLE_ENTRIES)) ? 5'(TABLE_ENTRIES) : v4_count_reg)
        : ((v6_count_reg > 5'(TABLE_ENTRIES)) ? 5'(TABLE_ENTRIES) : v6_count_reg);

    // entry modulo: four shift/compare-subtract steps per cycle, MSB first;
    // the remainder stays below lim, so one subtract per bit is enough
    always_comb
    begin
        part_step = {1'b0, part_reg};
        for (int b = 0; b < 4; b++)
        begin
            part_step = {part_step[4:0], rem_reg[31 - b]};
            if (part_step >= {1'b0, lim_reg})
                part_step = part_step - {1'b0, lim_reg};
        end
    end
    assign pick_idx = part_step[IW-1:0];

    // v4 host mask
    logic [5:0]  hb;
    logic [31:0] hmask, host;
    logic        host_ok;
    assign hb      = 6'd32 - {1'b0, bits_reg[4:0]};
    assign hmask   = 32'((33'd1 << hb) - 33'd1);
    assign host    = rnd & hmask;
    assign host_ok = (hb < 6'd2) || (host != 32'd0 && host != hmask);

    // v6 word mix for the current word
    logic [7:0]  bits6, off;
    logic [31:0] wnet, wmask, wmix;
    logic        wdraw;
    assign bits6 = (bits_reg > 8'd128) ? 8'd128 : bits_reg;
    assign off   = {1'b0, word_reg, 5'd0};
    always_comb
    begin
        case (word_reg)
            2'd0:    wnet = v6_net_reg[127:96];
            2'd1:    wnet = v6_net_reg[95:64];
            2'd2:    wnet = v6_net_reg[63:32];
            default: wnet = v6_net_reg[31:0];
        endcase
        wdraw = 1'b0;
        wmask = 32'd0;
        if (bits6 <= off)
        begin
            wdraw = 1'b1;
            wmix  = rnd;
        end
        else if (bits6 >= off + 8'd32)
            wmix = wnet;
        else
        begin
            wdraw = 1'b1;
            wmask = 32'((33'd1 << (6'(off + 8'd32 - bits6))) - 33'd1);
            wmix  = (wnet & ~wmask) | (rnd & wmask);
        end
    end

    function automatic rsp_t fail_rsp(input logic fb);
        rsp_t r;
        begin
            r = '0;
            r.status = fb ? ST_FALLBACK : ST_DENIED;
            return r;
        end
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept_in)
                    state_next = S_DRAW_IDX;
            S_DRAW_IDX:
                state_next = S_DONE;
            S_MOD:
                if (mod_cnt_reg == 3'd7)
                    state_next = S_READ;
            S_READ:
                if (use_v4_reg && bits_reg < 8'd32)
                    state_next = S_V4_TRY;
                else if (use_v4_reg)
                    state_next = S_DONE;
                else
                    state_next = S_V6_WORD;
            S_V4_TRY:
                if (host_ok || try_reg == TW'(HOST_TRIES - 1))
                    state_next = S_DONE;
            S_V6_WORD:
                if (word_reg == 2'd3)
                    state_next = S_DONE;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_DRAW_IDX && !pass && req_reg.opcode >= OP_DEST_V4
            && req_reg.opcode <= OP_BIND_V6 && cnt_sat != 5'd0)
            state_next = S_MOD;
    end

    // datapath controls
    always_comb
    begin
        rsp_next     = rsp_reg;
        rem_next     = rem_reg;
        part_next    = part_reg;
        mod_cnt_next = mod_cnt_reg;
        lim_next     = lim_reg;
        use_v4_next  = use_v4_reg;
        mapped_next  = mapped_reg;
        try_next     = try_reg;
        word_next    = word_reg;
        acc_next     = acc_reg;
        rng_step     = 1'b0;
        case (state_reg)
            S_DRAW_IDX:
            begin
                rsp_next     = '0;
                use_v4_next  = v4_path;
                mapped_next  = is_mapped && req_reg.opcode == OP_DEST_V6;
                lim_next     = cnt_sat;
                try_next     = '0;
                word_next    = 2'd0;
                part_next    = 5'd0;
                mod_cnt_next = 3'd0;
                if (req_reg.opcode == OP_LOAD_V4 || req_reg.opcode == OP_LOAD_V6)
                    rsp_next.status = ST_LOADED;
                else if (pass || req_reg.opcode > OP_BIND_V6)
                    rsp_next.status = ST_PASS;
                else if (cnt_sat == 5'd0)
                    rsp_next = fail_rsp(fallback_reg);
                else
                begin
                    rng_step = 1'b1;
                    rem_next = rnd;
                end
            end
            S_MOD:
            begin
                // one nibble of the drawn word per cycle
                rem_next     = rem_reg << 4;
                part_next    = part_step[4:0];
                mod_cnt_next = mod_cnt_reg + 3'd1;
            end
            S_READ:
                acc_next = '0;
            S_V4_TRY:
            begin
                rng_step = 1'b1;
                try_next = try_reg + 1'b1;
                if (host_ok)
                begin
                    rsp_next.status       = ST_PICKED;
                    rsp_next.source_is_v6 = mapped_reg;
                    rsp_next.source_high  = '0;
                    rsp_next.source_low   = {mapped_reg ? 32'h0000ffff : 32'd0,
                                             (net_reg & ~hmask) | host};
                end
                else if (try_reg == TW'(HOST_TRIES - 1))
                    rsp_next = fail_rsp(fallback_reg);
            end
            S_V6_WORD:
            begin
                rng_step  = wdraw;
                word_next = word_reg + 2'd1;
                acc_next  = {acc_reg[95:0], wmix};
                if (word_reg == 2'd3)
                begin
                    if (acc_reg[95:92] == 4'hf)
                        rsp_next = fail_rsp(fallback_reg);
                    else
                    begin
                        rsp_next.status       = ST_PICKED;
                        rsp_next.source_is_v6 = 1'b1;
                        rsp_next.source_high  = acc_reg[95:32];
                        rsp_next.source_low   = {acc_reg[31:0], wmix};
                    end
                end
            end
            default: ;
        endcase
        // stored v4 prefix of 32 or more returns the address without a draw
        if (state_reg == S_READ && use_v4_reg && bits_reg >= 8'd32)
        begin
            rsp_next.status       = ST_PICKED;
            rsp_next.source_is_v6 = mapped_reg;
            rsp_next.source_low   = {mapped_reg ? 32'h0000ffff : 32'd0, net_reg};
        end
    end

    // table entry fetch, registered; last S_MOD cycle produces the final index
    always_ff @(posedge clk)
    begin
        if (accept_in)
            req_reg <= in_ch.data;
        rsp_reg     <= rsp_next;
        rem_reg     <= rem_next;
        part_reg    <= part_next;
        mod_cnt_reg <= mod_cnt_next;
        lim_reg     <= lim_next;
        use_v4_reg  <= use_v4_next;
        mapped_reg  <= mapped_next;
        try_reg     <= try_next;
        word_reg    <= word_next;
        acc_reg     <= acc_next;
        if (state_reg == S_MOD && mod_cnt_reg == 3'd7)
        begin
            if (use_v4_reg)
            begin
                net_reg  <= v4_vld_reg[pick_idx] ? v4_addr_mem[pick_idx] : '0;
                bits_reg <= v4_vld_reg[pick_idx] ? v4_bits_mem[pick_idx] : '0;
            end
            else
            begin
                v6_net_reg <= v6_vld_reg[pick_idx]
                    ? {v6_hi_mem[pick_idx], v6_lo_mem[pick_idx]} : '0;
                bits_reg   <= v6_vld_reg[pick_idx] ? v6_bits_mem[pick_idx] : '0;
            end
        end
        if (state_reg == S_DRAW_IDX && 32'(req_reg.entry_index) < 32'(TABLE_ENTRIES))
        begin
            if (req_reg.opcode == OP_LOAD_V4)
            begin
                v4_addr_mem[req_reg.entry_index[IW-1:0]] <= req_reg.address_low[31:0];
                v4_bits_mem[req_reg.entry_index[IW-1:0]] <= req_reg.prefix_length;
            end
            if (req_reg.opcode == OP_LOAD_V6)
            begin
                v6_hi_mem[req_reg.entry_index[IW-1:0]]   <= req_reg.address_high;
                v6_lo_mem[req_reg.entry_index[IW-1:0]]   <= req_reg.address_low;
                v6_bits_mem[req_reg.entry_index[IW-1:0]] <= req_reg.prefix_length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            v4_vld_reg    <= '0;
            v6_vld_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE)
                rsp_valid_reg <= 1'b1;
            else if (out_ch.ready)
                rsp_valid_reg <= 1'b0;
            if (state_reg == S_DRAW_IDX && 32'(req_reg.entry_index) < 32'(TABLE_ENTRIES))
            begin
                if (req_reg.opcode == OP_LOAD_V4)
                    v4_vld_reg[req_reg.entry_index[IW-1:0]] <= 1'b1;
                if (req_reg.opcode == OP_LOAD_V6)
                    v6_vld_reg[req_reg.entry_index[IW-1:0]] <= 1'b1;
            end
        end
    end

    `RSAP_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready,
        "input accepted while busy")
    `RSAP_ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_ch.valid,
        "result not presented after done")
    `RSAP_ASSERT_IMPL(a_try_bound, clk, rst_n, state_reg == S_V4_TRY,
        try_reg < TW'(HOST_TRIES), "host try count overrun")
endmodule
`default_nettype wire

// File: tb/sv/tb_random_source_address_picker_core.sv
// Testbench for the random source address picker: directed and random items.
`timescale 1ns / 1ps
`default_nettype none
module tb_random_source_address_picker_core;
    import rsap_pkg::*;

    // opcodes with no function
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rsap_if #(.T(req_t)) req_ch ();
    rsap_if #(.T(rsp_t)) rsp_ch ();

    random_source_address_picker_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch.sink),
        .out_ch  (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Shadow of the block: registers, tables and generator.
    logic [4:0]  sh_v4_count;
    logic [4:0]  sh_v6_count;
    logic        sh_fallback;
    logic [31:0] sh_rng;
    logic [31:0] sh_v4_addr [16];
    logic [7:0]  sh_v4_bits [16];
    logic [63:0] sh_v6_up [16];
    logic [63:0] sh_v6_lo [16];
    logic [7:0]  sh_v6_bits [16];

    rsp_t pending_sources [$];
    int   mismatches;
    int   results_seen;
    int   picks_seen;
    int   send_idle_pct;
    int   recv_stall_pct;

    function automatic logic [31:0] next_word();
        logic [31:0] x;
        x = sh_rng;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        sh_rng = x;
        return x;
    endfunction

    function automatic logic is_special_v4(input logic [31:0] a);
        return (a[31:24] == 8'h7f) || (a[31:28] == 4'he) || (a == 32'hffffffff);
    endfunction

    // Chooses an entry; returns 0 when the table is empty.
    function automatic logic choose_row(input logic [4:0] cnt, output int row);
        int lim;
        row = 0;
        lim = (cnt > 16) ? 16 : cnt;
        if (lim == 0)
            return 1'b0;
        row = next_word() % lim;
        return 1'b1;
    endfunction

    function automatic logic pick_v4_source(output logic [31:0] src);
        int          row;
        int          hb;
        logic [31:0] mask;
        logic [31:0] host;
        src = '0;
        if (!choose_row(sh_v4_count, row))
            return 1'b0;
        if (sh_v4_bits[row] >= 32)
        begin
            src = sh_v4_addr[row];
            return 1'b1;
        end
        hb = 32 - sh_v4_bits[row];
        mask = (hb == 32) ? 32'hffffffff : ((32'd1 << hb) - 1);
        for (int t = 0; t < 8; t++)
        begin
            host = next_word() & mask;
            if (hb < 2 || (host != 0 && host != mask))
            begin
                src = (sh_v4_addr[row] & ~mask) | host;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] fill_word(input logic [31:0] net, input int bits,
                                              input int off);
        int          hb;
        logic [31:0] mask;
        if (bits <= off)
            return next_word();
        if (bits >= off + 32)
            return net;
        hb = off + 32 - bits;
        mask = (32'd1 << hb) - 1;
        return (net & ~mask) | (next_word() & mask);
    endfunction

    function automatic logic pick_v6_source(output logic [63:0] hi, output logic [63:0] lo);
        int          row;
        int          bits;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        hi = '0;
        lo = '0;
        if (!choose_row(sh_v6_count, row))
            return 1'b0;
        bits = (sh_v6_bits[row] > 128) ? 128 : sh_v6_bits[row];
        w0 = fill_word(sh_v6_up[row][63:32], bits, 0);
        w1 = fill_word(sh_v6_up[row][31:0], bits, 32);
        w2 = fill_word(sh_v6_lo[row][63:32], bits, 64);
        w3 = fill_word(sh_v6_lo[row][31:0], bits, 96);
        if (w0[31:28] == 4'hf)
            return 1'b0;
        hi = {w0, w1};
        lo = {w2, w3};
        return 1'b1;
    endfunction

    // Works out the result of one request and updates the shadow.
    function automatic rsp_t predict_source(input req_t r);
        rsp_t        o;
        logic        skip;
        logic        ok;
        logic        mapped;
        logic [31:0] a4;
        logic [63:0] hi;
        logic [63:0] lo;
        o = '0;
        o.status = ST_PASS;
        mapped = (r.address_high == 0) && (r.address_low[63:32] == 32'h0000ffff);
        if (r.opcode == OP_LOAD_V4 || r.opcode == OP_LOAD_V6)
        begin
            if (r.opcode == OP_LOAD_V4)
            begin
                sh_v4_addr[r.entry_index] = r.address_low[31:0];
                sh_v4_bits[r.entry_index] = r.prefix_length;
            end
            else
            begin
                sh_v6_up[r.entry_index] = r.address_high;
                sh_v6_lo[r.entry_index] = r.address_low;
                sh_v6_bits[r.entry_index] = r.prefix_length;
            end
            o.status = ST_LOADED;
        end
        else if (r.opcode <= OP_BIND_V6)
        begin
            case (r.opcode)
                OP_DEST_V4: skip = is_special_v4(r.address_low[31:0]);
                OP_DEST_V6: skip = (r.address_high == 0 && r.address_low == 1)
                                || r.address_high[63:56] == 8'hff
                                || r.address_high[63:54] == 10'b1111111010
                                || (mapped && is_special_v4(r.address_low[31:0]));
                OP_BIND_V4: skip = r.address_low[31:0] != 0;
                default:    skip = r.address_high != 0 || r.address_low != 0;
            endcase
            if (!skip)
            begin
                if (r.opcode == OP_DEST_V4 || r.opcode == OP_BIND_V4)
                begin
                    ok = pick_v4_source(a4);
                    o.source_low = {32'd0, a4};
                end
                else if (r.opcode == OP_DEST_V6 && mapped)
                begin
                    ok = pick_v4_source(a4);
                    o.source_low = {32'h0000ffff, a4};
                    o.source_is_v6 = 1'b1;
                end
                else
                begin
                    ok = pick_v6_source(hi, lo);
                    o.source_high = hi;
                    o.source_low = lo;
                    o.source_is_v6 = 1'b1;
                end
                if (ok)
                    o.status = ST_PICKED;
                else
                begin
                    o = '0;
                    o.status = sh_fallback ? ST_FALLBACK : ST_DENIED;
                end
            end
        end
        return o;
    endfunction

    // APB write: setup phase, access phase, then the bus goes idle; shadow follows.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_V4_COUNT: sh_v4_count = val[4:0];
            REG_V6_COUNT: sh_v6_count = val[4:0];
            REG_FALLBACK: sh_fallback = val[0];
            default:      sh_rng = (val != 0) ? val : 32'd1;
        endcase
    endtask

    // Sends one item, with random idle cycles in front of it.
    task automatic send_request(input req_t r);
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        pending_sources.push_back(predict_source(r));
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        req_ch.valid <= 1'b0;
        // block is busy right after acceptance, so this costs no throughput
        @(posedge clk);
    endtask

    // Waits for the queue to drain, then for the block to settle.
    task automatic drain();
        while (pending_sources.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic req_t make_req(input logic [2:0] op, input logic [3:0] idx,
                                      input logic [7:0] plen, input logic [63:0] hi,
                                      input logic [63:0] lo);
        req_t r;
        r.opcode = op;
        r.entry_index = idx;
        r.prefix_length = plen;
        r.address_high = hi;
        r.address_low = lo;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request: table loads, dest and bind picks, and some random opcodes.
    function automatic req_t random_req();
        req_t        r;
        int          sel;
        logic [7:0]  plen;
        r = make_req(3'($urandom_range(7)), 4'($urandom), 8'($urandom), rand64(), rand64());
        sel = $urandom_range(99);
        plen = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 128));
        r.prefix_length = plen;
        if (sel < 15)
            r.opcode = OP_LOAD_V4;
        else if (sel < 30)
            r.opcode = OP_LOAD_V6;
        else if (sel < 50)
            r.opcode = OP_DEST_V4;
        else if (sel < 65)
        begin
            r.opcode = OP_DEST_V6;
            if ($urandom_range(2) == 0)
            begin
                r.address_high = 0;
                r.address_low[63:32] = 32'h0000ffff;
            end
        end
        else if (sel < 75)
        begin
            r.opcode = OP_BIND_V4;
            if ($urandom_range(2) != 0)
                r.address_low[31:0] = 0;
        end
        else if (sel < 85)
        begin
            r.opcode = OP_BIND_V6;
            if ($urandom_range(2) != 0)
            begin
                r.address_high = 0;
                r.address_low = 0;
            end
        end
        return r;
    endfunction

    // Result checker: receiver stalls at random, compares with oldest prediction.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            results_seen++;
            if (pending_sources.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", rsp_ch.data);
            end
            else
            begin
                want = pending_sources.pop_front();
                if (want.status == ST_PICKED)
                    picks_seen++;
                if (rsp_ch.data.status !== want.status
                    || rsp_ch.data.source_is_v6 !== want.source_is_v6
                    || rsp_ch.data.source_high !== want.source_high
                    || rsp_ch.data.source_low !== want.source_low)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, rsp_ch.data);
                end
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic test_reset_state();
        // Empty tables after reset: picks deny, specials and spare opcodes pass.
        send_request(make_req(OP_DEST_V4, 0, 0, 0, 64'h0a000001));
        send_request(make_req(OP_DEST_V4, 0, 0, 0, 64'h7f000001));
        send_request(make_req(OP_DEST_V6, 0, 0, 64'hfe80000000000000, 0));
        send_request(make_req(OP_SPARE_A, 0, 0, '1, '1));
        send_request(make_req(OP_SPARE_B, 15, 255, 0, 0));
        drain();
    endtask

    task automatic test_directed();
        write_reg(REG_V4_COUNT, 31);
        write_reg(REG_V6_COUNT, 16);
        write_reg(REG_FALLBACK, 1);
        write_reg(REG_SEED, 0);
        send_request(make_req(OP_LOAD_V4, 0, 24, '1, 64'hffffffff_c0a80100));
        send_request(make_req(OP_LOAD_V4, 1, 32, 0, 64'h0a0a0a0a));
        send_request(make_req(OP_LOAD_V4, 2, 31, 0, 64'h0b000000));
        send_request(make_req(OP_LOAD_V4, 3, 255, 0, 64'h01020304));
        send_request(make_req(OP_LOAD_V6, 0, 64, 64'h20010db800000000, 0));
        send_request(make_req(OP_LOAD_V6, 1, 255, '1, '1));
        send_request(make_req(OP_LOAD_V6, 2, 0, 0, 0));
        send_request(make_req(OP_LOAD_V6, 15, 100, 64'hf000000000000000, 5));
        send_request(make_req(OP_DEST_V4, 0, 0, '1, 64'hffffffff));
        send_request(make_req(OP_DEST_V4, 0, 0, 0, 64'he0000001));
        send_request(make_req(OP_DEST_V4, 0, 0, 0, 64'h08080808));
        send_request(make_req(OP_DEST_V6, 0, 0, 0, 1));
        send_request(make_req(OP_DEST_V6, 0, 0, 64'hff02000000000000, 0));
        send_request(make_req(OP_DEST_V6, 0, 0, 0, 64'h0000ffff_7f000001));
        send_request(make_req(OP_DEST_V6, 0, 0, 0, 64'h0000ffff_08080808));
        send_request(make_req(OP_DEST_V6, 0, 0, 64'h2606000000000000, 9));
        send_request(make_req(OP_BIND_V4, 0, 0, '1, 0));
        send_request(make_req(OP_BIND_V4, 0, 0, 0, 5));
        send_request(make_req(OP_BIND_V6, 0, 0, 0, 0));
        send_request(make_req(OP_BIND_V6, 0, 0, 1, 0));
        drain();
    endtask

    task automatic test_random_phase(input int items, input int idle, input int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_reg(REG_V4_COUNT, $urandom_range(0, 31));
        write_reg(REG_V6_COUNT, $urandom_range(0, 31));
        write_reg(REG_FALLBACK, $urandom_range(1));
        write_reg(REG_SEED, $urandom);
        for (int i = 0; i < items; i++)
        begin
            send_request(random_req());
            // hold off once, halfway, until everything is back
            if (i == items / 2)
                while (pending_sources.size() != 0)
                    @(posedge clk);
        end
        drain();
    endtask

    task automatic test_extreme_settings();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_V4_COUNT, 0);
        write_reg(REG_V6_COUNT, 0);
        write_reg(REG_FALLBACK, 0);
        write_reg(REG_SEED, 32'hffffffff);
        for (int i = 0; i < 20; i++)
            send_request(random_req());
        drain();
        write_reg(REG_V4_COUNT, 16);
        write_reg(REG_V6_COUNT, 31);
        write_reg(REG_SEED, 32'h80000000);
        for (int i = 0; i < 30; i++)
            send_request(random_req());
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        mismatches = 0;
        results_seen = 0;
        picks_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sh_v4_count = 0;
        sh_v6_count = 0;
        sh_fallback = 0;
        sh_rng = 32'd1;
        for (int i = 0; i < 16; i++)
        begin
            sh_v4_addr[i] = 0;
            sh_v4_bits[i] = 0;
            sh_v6_up[i] = 0;
            sh_v6_lo[i] = 0;
            sh_v6_bits[i] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed();
        test_random_phase(120, 0, 0);
        test_random_phase(110, 72, 0);
        test_random_phase(110, 0, 72);
        test_random_phase(110, 16, 16);
        test_extreme_settings();

        $display("covered %0d results, %0d picked sources, over loads, dest, bind",
                 results_seen, picks_seen);
        $display("and unused opcodes under several register settings and idle mixes");
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

// File: random_source_address_picker_core.f
+incdir+sv
sv/rsap_pkg.sv
sv/rsap_if.sv
sv/rsap_rng.sv
sv/random_source_address_picker_core.sv
tb/sv/tb_random_source_address_picker_core.sv
